// File: design/rsrd_pkg.sv
// ----------------------------------------------------------------------------
// rsrd_pkg
// Shared types and constants for the run-coded sprite row decoder.
// ----------------------------------------------------------------------------
package rsrd_pkg;

  localparam int unsigned ADDR_BITS_DEF = 24;
  localparam int unsigned STRIDE_W      = 13;
  localparam int unsigned OUT_ADDR_W    = 24;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;

  localparam logic [7:0] EMPTY_ROW_MARK = 8'hff;
  localparam logic [7:0] OPAQUE_ESCAPE  = 8'hfe;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_XSTART,
    PH_LEN,
    PH_ESCLEN,
    PH_PIXELS
  } phase_e;

  typedef struct packed {
    logic                  write_enable;
    logic [OUT_ADDR_W-1:0] pixel_address;
    logic [7:0]            pixel_value;
    logic                  sprite_done;
  } result_t;

endpackage

// File: design/rsrd_core.sv
// ----------------------------------------------------------------------------
// rsrd_core
// Run stream decode state and per-item result computation.
// ----------------------------------------------------------------------------
module rsrd_core #(
  parameter int unsigned ADDR_BITS = rsrd_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsrd_pkg::STRIDE_W-1:0] cfg_wdata_i,
  input  logic                          fire_i,
  input  logic                          op_i,
  input  logic signed [11:0]            origin_x_i,
  input  logic signed [11:0]            origin_y_i,
  input  logic signed [15:0]            top_offset_i,
  input  logic [14:0]                   coded_rows_i,
  input  logic [7:0]                    data_byte_i,
  output rsrd_pkg::result_t             result_o
);

  localparam int unsigned AW = ADDR_BITS;

  logic [rsrd_pkg::STRIDE_W-1:0] row_stride_q;
  rsrd_pkg::phase_e              phase_q, phase_d;
  logic [7:0]                    run_start_x_q, run_start_x_d;
  logic [7:0]                    run_left_q, run_left_d;
  logic                          opaque_run_q, opaque_run_d;
  logic [14:0]                   rows_left_q, rows_left_d;
  logic signed [17:0]            screen_row_q, screen_row_d;
  logic [AW-1:0]                 row_address_q, row_address_d;
  logic [7:0]                    pixel_column_q, pixel_column_d;

  logic signed [16:0] y0;
  logic signed [30:0] prod;
  logic [32:0]        start_sum;
  logic [AW-1:0]      stride_ext;
  logic [AW-1:0]      pix_addr;
  logic [AW+23:0]     addr_wide;
  logic [14:0]        rows_dec;
  logic [7:0]         run_dec;
  logic               end_row;
  logic               begin_run;
  logic [7:0]         run_len;

  assign y0         = 17'(origin_y_i) + 17'(top_offset_i);
  assign prod       = 31'(y0) * 31'($signed({1'b0, row_stride_q}));
  assign start_sum  = 33'(prod) + 33'(origin_x_i);
  assign stride_ext = {{(AW-rsrd_pkg::STRIDE_W){1'b0}}, row_stride_q};
  assign pix_addr   = row_address_q + {{(AW-8){1'b0}}, run_start_x_q}
                      + {{(AW-8){1'b0}}, pixel_column_q};
  assign addr_wide  = {24'd0, pix_addr};
  assign rows_dec   = rows_left_q - 15'd1;
  assign run_dec    = run_left_q - 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_stride_q <= rsrd_pkg::STRIDE_RESET;
    end else if (cfg_we_i) begin
      row_stride_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= rsrd_pkg::PH_IDLE;
      run_start_x_q  <= '0;
      run_left_q     <= '0;
      opaque_run_q   <= 1'b0;
      rows_left_q    <= '0;
      screen_row_q   <= '0;
      row_address_q  <= '0;
      pixel_column_q <= '0;
    end else if (fire_i) begin
      phase_q        <= phase_d;
      run_start_x_q  <= run_start_x_d;
      run_left_q     <= run_left_d;
      opaque_run_q   <= opaque_run_d;
      rows_left_q    <= rows_left_d;
      screen_row_q   <= screen_row_d;
      row_address_q  <= row_address_d;
      pixel_column_q <= pixel_column_d;
    end
  end

  always_comb begin
    phase_d        = phase_q;
    run_start_x_d  = run_start_x_q;
    run_left_d     = run_left_q;
    opaque_run_d   = opaque_run_q;
    rows_left_d    = rows_left_q;
    screen_row_d   = screen_row_q;
    row_address_d  = row_address_q;
    pixel_column_d = pixel_column_q;
    result_o       = '0;
    end_row        = 1'b0;
    begin_run      = 1'b0;
    run_len        = data_byte_i;

    if (op_i == rsrd_pkg::OP_START) begin
      screen_row_d   = 18'(y0);
      row_address_d  = start_sum[AW-1:0];
      rows_left_d    = coded_rows_i;
      run_start_x_d  = '0;
      run_left_d     = '0;
      opaque_run_d   = 1'b0;
      pixel_column_d = '0;
      if (coded_rows_i == 15'd0) begin
        phase_d              = rsrd_pkg::PH_IDLE;
        result_o.sprite_done = 1'b1;
      end else begin
        phase_d = rsrd_pkg::PH_XSTART;
      end
    end else begin
      unique case (phase_q)
        rsrd_pkg::PH_XSTART: begin
          if (data_byte_i == rsrd_pkg::EMPTY_ROW_MARK) begin
            end_row = 1'b1;
          end else begin
            run_start_x_d = data_byte_i;
            phase_d       = rsrd_pkg::PH_LEN;
          end
        end
        rsrd_pkg::PH_LEN: begin
          if (data_byte_i == rsrd_pkg::OPAQUE_ESCAPE) begin
            opaque_run_d = 1'b1;
            phase_d      = rsrd_pkg::PH_ESCLEN;
          end else begin
            opaque_run_d = 1'b0;
            begin_run    = 1'b1;
          end
        end
        rsrd_pkg::PH_ESCLEN: begin
          begin_run = 1'b1;
        end
        rsrd_pkg::PH_PIXELS: begin
          if (!screen_row_q[17] && (opaque_run_q || (data_byte_i != 8'd0))) begin
            result_o.write_enable  = 1'b1;
            result_o.pixel_address = addr_wide[23:0];
            result_o.pixel_value   = data_byte_i;
          end
          pixel_column_d = pixel_column_q + 8'd1;
          run_left_d     = run_dec;
          end_row        = (run_dec == 8'd0);
        end
        default: begin
        end
      endcase

      if (begin_run) begin
        if (run_len == 8'd0) begin
          end_row = 1'b1;
        end else begin
          run_left_d     = run_len;
          pixel_column_d = '0;
          phase_d        = rsrd_pkg::PH_PIXELS;
        end
      end

      if (end_row) begin
        rows_left_d    = rows_dec;
        screen_row_d   = screen_row_q + 18'sd1;
        row_address_d  = row_address_q + stride_ext;
        pixel_column_d = '0;
        run_left_d     = '0;
        if (rows_dec == 15'd0) begin
          phase_d              = rsrd_pkg::PH_IDLE;
          result_o.sprite_done = 1'b1;
        end else begin
          phase_d = rsrd_pkg::PH_XSTART;
        end
      end
    end
  end

endmodule

// File: design/rsrd_out_buf.sv
// ----------------------------------------------------------------------------
// rsrd_out_buf
// Result register with a skid entry so input stall is fully registered.
// ----------------------------------------------------------------------------
module rsrd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  rsrd_pkg::result_t result_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsrd_pkg::result_t result_o
);

  logic              main_valid_q;
  logic              skid_valid_q;
  rsrd_pkg::result_t main_q;
  rsrd_pkg::result_t skid_q;
  logic              take;

  assign take        = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign result_o    = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= fire_i;
      end
    end else if (fire_i) begin
      if (!main_valid_q) begin
        main_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (skid_valid_q) begin
        main_q <= skid_q;
      end else if (fire_i) begin
        main_q <= result_i;
      end
    end else if (fire_i) begin
      if (!main_valid_q) begin
        main_q <= result_i;
      end else begin
        skid_q <= result_i;
      end
    end
  end

endmodule

// File: design/rle_sprite_row_decoder.sv
// ----------------------------------------------------------------------------
// rle_sprite_row_decoder
// Turns a run-coded 8-bit sprite byte stream into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Takes one item per clock while the input is not stalled and returns exactly
// one result per item, registered in the result buffer after its transfer. All
// decoding is combinational between the decode state registers and a two-entry
// result buffer; the longest path is the start item's 17x13 row origin
// multiply plus add. The input stall comes straight from the buffer's skid
// flag, so the two channels share no combinational path.
module rle_sprite_row_decoder #(
  parameter int unsigned ADDR_BITS = rsrd_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsrd_pkg::STRIDE_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic signed [11:0]            origin_x_i,
  input  logic signed [11:0]            origin_y_i,
  input  logic signed [15:0]            top_offset_i,
  input  logic [14:0]                   coded_rows_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          write_enable_o,
  output logic [23:0]                   pixel_address_o,
  output logic [7:0]                    pixel_value_o,
  output logic                          sprite_done_o
);

  logic              fire;
  logic              full;
  rsrd_pkg::result_t core_res;
  rsrd_pkg::result_t out_res;

  assign fire       = in_valid_i && !full;
  assign in_stall_o = full;

  rsrd_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .op_i        (op_i),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .top_offset_i(top_offset_i),
    .coded_rows_i(coded_rows_i),
    .data_byte_i (data_byte_i),
    .result_o    (core_res)
  );

  rsrd_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .result_i   (core_res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (out_res)
  );

  assign write_enable_o  = out_res.write_enable;
  assign pixel_address_o = out_res.pixel_address;
  assign pixel_value_o   = out_res.pixel_value;
  assign sprite_done_o   = out_res.sprite_done;

`ifndef SYNTHESIS
  a_skid_implies_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid entry held while result register empty");

  a_no_write_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (pixel_address_o == 24'd0 && pixel_value_o == 8'd0))
    else $error("payload not cleared on a result without write");

  a_start_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o && op_i == rsrd_pkg::OP_START)
      |=> (out_valid_o && !write_enable_o))
    else $error("start transfer produced a pixel write");

  a_stall_clears_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_stall_o && !out_stall_i) |=> !in_stall_o)
    else $error("skid entry not drained after a result transfer");
`endif

endmodule
